### src/linear_probe_hash_set_top_assert.svh
// Assertion macros for the linear probing hash set.
// Included by the RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef LINEAR_PROBE_HASH_SET_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is asserted
`define LPHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that also holds during reset
`define LPHS_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LPHS_ASSERT(label, prop, msg)
`define LPHS_ASSERT_NR(label, prop, msg)
`endif
`endif

### src/lphs_pkg.sv
// Shared types and constants of the linear probing hash set.
// No dependencies; used by the front end, queue, back end and top level.
`timescale 1ns / 1ps

package lphs_pkg;

  localparam int unsigned KEY_W       = 31;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_KEY  = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

endpackage

### src/lphs_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Payload types come from lphs_pkg at the instantiation site.
`timescale 1ns / 1ps

interface lphs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/lphs_front.sv
// Front end: takes a request transfer, reduces the key modulo the table size.
// Reciprocal multiply, multiply-subtract, one correction; depends on lphs_pkg, lphs_stream_if.
`timescale 1ns / 1ps

module lphs_front #(
  parameter int unsigned TABLE_SIZE = 31,
  localparam int unsigned IdxW = $clog2(TABLE_SIZE)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lphs_stream_if.sink         req_i,
  input  logic                clear_done_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output lphs_pkg::req_t      job_o,
  output logic [IdxW-1:0]     home_o
);

  localparam logic [IdxW:0] TsWide = (IdxW+1)'(TABLE_SIZE);
  // floor(2^KEY_W / TABLE_SIZE): the quotient estimate is low by at most one
  localparam logic [lphs_pkg::KEY_W-1:0] Recip =
    lphs_pkg::KEY_W'((64'd1 << lphs_pkg::KEY_W) / TABLE_SIZE);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_QUOT = 5'b00010,
    F_PROD = 5'b00100,
    F_FIX  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_e;

  front_state_e                   state_q, state_d;
  lphs_pkg::req_t                 job_q, job_d;
  logic [lphs_pkg::KEY_W-1:0]     quot_q, quot_d;
  logic [IdxW:0]                  est_q, est_d;
  logic [IdxW-1:0]                rem_q, rem_d;
  logic [2*lphs_pkg::KEY_W-1:0]   prod;
  logic [IdxW:0]                  qt_low;
  logic                           in_ready;

  assign in_ready    = (state_q == F_IDLE) && clear_done_i;
  assign req_i.ready = in_ready;
  assign prod        = {{lphs_pkg::KEY_W{1'b0}}, job_q.key} *
                       {{lphs_pkg::KEY_W{1'b0}}, Recip};
  // key - q*T lies in [0, 2*TABLE_SIZE), so its low IdxW+1 bits are exact
  assign qt_low      = quot_q[IdxW:0] * TsWide;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    quot_d  = quot_q;
    est_d   = est_q;
    rem_d   = rem_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid && in_ready) begin
          job_d   = req_i.payload;
          // zero key skips the reduction; the back end answers it directly
          state_d = (req_i.payload.key == '0) ? F_PUSH : F_QUOT;
        end
      end
      F_QUOT: begin
        quot_d  = prod[2*lphs_pkg::KEY_W-1:lphs_pkg::KEY_W];
        state_d = F_PROD;
      end
      F_PROD: begin
        est_d   = job_q.key[IdxW:0] - qt_low;
        state_d = F_FIX;
      end
      F_FIX: begin
        rem_d   = (est_q >= TsWide) ? IdxW'(est_q - TsWide) : est_q[IdxW-1:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    quot_q <= quot_d;
    est_q  <= est_d;
    rem_q  <= rem_d;
  end

  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = job_q;
  assign home_o      = rem_q;

endmodule

### src/lphs_fifo.sv
// Short job queue between front and back end.
// Depth fixed by lphs_pkg::QUEUE_DEPTH (power of two); depends on lphs_pkg.
`timescale 1ns / 1ps

module lphs_fifo #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = lphs_pkg::QUEUE_PTR_W;
  localparam logic [PtrW:0] Full = (PtrW+1)'(lphs_pkg::QUEUE_DEPTH);

  logic [Width-1:0] data_q [lphs_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = data_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/lphs_back.sv
// Back end: slot store, clearing pass, probe sequencer and result register.
// Depends on lphs_pkg, lphs_stream_if and the assertion macro header.
`timescale 1ns / 1ps
`include "linear_probe_hash_set_top_assert.svh"

module lphs_back #(
  parameter int unsigned TABLE_SIZE = 31,
  localparam int unsigned IdxW = $clog2(TABLE_SIZE)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  lphs_pkg::req_t  job_i,
  input  logic [IdxW-1:0] home_i,
  output logic            clear_done_o,
  lphs_stream_if.source   rsp_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_PROBE = 3'b100
  } back_state_e;

  back_state_e                state_q, state_d;
  lphs_pkg::req_t             job_q, job_d;
  logic [IdxW-1:0]            pos_q, pos_d;
  logic [IdxW-1:0]            cnt_q, cnt_d;
  logic                       rsp_valid_q, rsp_valid_d;
  lphs_pkg::rsp_t             rsp_q, rsp_d;

  logic [lphs_pkg::KEY_W-1:0] mem_q [TABLE_SIZE];
  logic [lphs_pkg::KEY_W-1:0] rdata_q;
  logic                       mem_we;
  logic [IdxW-1:0]            mem_waddr;
  logic [lphs_pkg::KEY_W-1:0] mem_wdata;
  logic [IdxW-1:0]            rd_addr;

  logic [IdxW-1:0]            next_pos;
  logic                       out_free;
  logic                       slot_empty, slot_match, pass_done;

  assign next_pos   = (pos_q == LastIdx) ? '0 : pos_q + IdxW'(1);
  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign slot_empty = (rdata_q == '0);
  assign slot_match = (rdata_q == job_q.key);
  assign pass_done  = (cnt_q == LastIdx);

  assign job_ready_o  = (state_q == B_IDLE) && out_free;
  assign clear_done_o = (state_q != B_CLEAR);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = job_q.key;
    // the slot after the current one is read every probe cycle, ahead of need
    rd_addr     = next_pos;
    unique case (state_q)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = '0;
        cnt_d     = cnt_q + IdxW'(1);
        if (pass_done) begin
          cnt_d   = '0;
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        rd_addr = home_i;
        if (job_valid_i && job_ready_o) begin
          if (job_i.key == '0) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: lphs_pkg::ST_ZERO_KEY, slot_index: '0};
          end else begin
            job_d   = job_i;
            pos_d   = home_i;
            cnt_d   = '0;
            state_d = B_PROBE;
          end
        end
      end
      B_PROBE: begin
        if (job_q.cmd == lphs_pkg::CMD_INSERT) begin
          if (slot_empty) begin
            mem_we      = 1'b1;
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: lphs_pkg::ST_INSERTED,
                            slot_index: lphs_pkg::SLOT_W'(pos_q)};
            state_d     = B_IDLE;
          end else if (pass_done) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: lphs_pkg::ST_FULL, slot_index: '0};
            state_d     = B_IDLE;
          end else begin
            pos_d = next_pos;
            cnt_d = cnt_q + IdxW'(1);
          end
        end else begin
          if (slot_match) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: lphs_pkg::ST_FOUND,
                            slot_index: lphs_pkg::SLOT_W'(pos_q)};
            state_d     = B_IDLE;
          end else if (slot_empty || pass_done) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: lphs_pkg::ST_NOT_FOUND, slot_index: '0};
            state_d     = B_IDLE;
          end else begin
            pos_d = next_pos;
            cnt_d = cnt_q + IdxW'(1);
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    pos_q <= pos_d;
    rsp_q <= rsp_d;
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  `LPHS_ASSERT_NR(a_probe_out_empty, (state_q == B_PROBE) |-> !rsp_valid_q, "result register busy during probe")
  `LPHS_ASSERT_NR(a_probe_pos_range, (state_q == B_PROBE) |-> (pos_q <= LastIdx), "probe position out of table")
  `LPHS_ASSERT(a_clear_once, (state_q != B_CLEAR) |=> (state_q != B_CLEAR), "clearing pass re-entered")
  `LPHS_ASSERT(a_write_empty_only, (mem_we && state_q == B_PROBE) |-> (job_q.cmd == lphs_pkg::CMD_INSERT && rdata_q == '0), "probe wrote an occupied slot")

endmodule

### src/linear_probe_hash_set_top.sv
// Path: the front end reduces the key mod TABLE_SIZE, then the back end probes P slots,
//   P = slots probed (1..TABLE_SIZE); a zero key skips the reduction and the probe.
// Throughput: the front end takes a new request only once its last one is queued, and can
//   hash the next key while the back end probes, one slot-store read per probe.
// Reset: asynchronous, active low; then a clearing pass zeroes the slot store, during
//   which req_i.ready stays low.
`timescale 1ns / 1ps

// Linear probing hash set, top level.
// Depends on lphs_pkg, lphs_stream_if, lphs_front, lphs_fifo, lphs_back.
module linear_probe_hash_set_top #(
  parameter int unsigned TABLE_SIZE = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lphs_stream_if.sink   req_i,
  lphs_stream_if.source rsp_o
);

  localparam int unsigned IdxW   = $clog2(TABLE_SIZE);
  localparam int unsigned QWidth = $bits(lphs_pkg::req_t) + IdxW;

  // front end -> queue
  logic                  f_valid, f_ready;
  lphs_pkg::req_t        f_job;
  logic [IdxW-1:0]       f_home;
  logic [QWidth-1:0]     q_in;

  // queue -> back end
  logic                  b_valid, b_ready;
  logic [QWidth-1:0]     q_out;
  lphs_pkg::req_t        b_job;
  logic [IdxW-1:0]       b_home;

  // back end tells the front end when the slot store is usable
  logic                  clear_done;

  // Front end: request transfer, zero-key check, home slot = key mod TABLE_SIZE.
  lphs_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .clear_done_i (clear_done),
    .job_valid_o  (f_valid),
    .job_ready_i  (f_ready),
    .job_o        (f_job),
    .home_o       (f_home)
  );

  // Queue entry: the request plus its home slot. Lets the front end hash the next
  // key while the back end is still probing.
  assign q_in = {f_job, f_home};

  lphs_fifo #(
    .Width (QWidth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  assign {b_job, b_home} = q_out;

  // Back end: slot store, one probe per cycle with the next slot read ahead,
  // result held in an output register; a stalled sink blocks the back end, and the front end once the queue is full.
  lphs_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (b_valid),
    .job_ready_o  (b_ready),
    .job_i        (b_job),
    .home_i       (b_home),
    .clear_done_o (clear_done),
    .rsp_o        (rsp_o)
  );

endmodule
